[sv/skts_pkg.sv]
// ----------------------------------------------------------------------------
// skts_pkg: shared definitions for the sorted key table search
// Command and status codes, default sizes and the compare result type.
// ----------------------------------------------------------------------------
package skts_pkg;

    // default sizes
    localparam int DEF_TABLE_DEPTH = 4096;
    localparam int DEF_KEY_BITS    = 32;

    // fixed field widths of the transaction ports
    localparam int CMD_BITS    = 2;
    localparam int IN_KEY_BITS = 32;
    localparam int STAT_BITS   = 2;
    localparam int POS_BITS    = 12;

    // command codes
    localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_LOOKUP = 2'd2;

    // status codes
    localparam logic [STAT_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_BITS-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_BITS-1:0] ST_ORDER = 2'd2;
    localparam logic [STAT_BITS-1:0] ST_UNUSED = 2'd3;

    // result of the shared key comparator (stored key versus probe key)
    typedef struct packed {
        logic lt;   // stored key below probe key
        logic eq;   // stored key equals probe key
    } t_cmp;

endpackage

[sv/skts_ram.sv]
// ----------------------------------------------------------------------------
// skts_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module skts_ram #(
    parameter int WIDTH = skts_pkg::DEF_KEY_BITS,
    parameter int DEPTH = skts_pkg::DEF_TABLE_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[sv/skts_cmp.sv]
// ----------------------------------------------------------------------------
// skts_cmp: shared key comparator
// Unsigned less-than and equality of a stored key against a probe key.
// ----------------------------------------------------------------------------
module skts_cmp #(
    parameter int KEY_BITS = skts_pkg::DEF_KEY_BITS
) (
    input  logic [KEY_BITS-1:0] i_stored,
    input  logic [KEY_BITS-1:0] i_probe,
    output skts_pkg::t_cmp      o_res
);

    always_comb begin
        o_res.lt = (i_stored < i_probe);
        o_res.eq = (i_stored == i_probe);
    end

endmodule

[sv/skts_seq.sv]
// ----------------------------------------------------------------------------
// skts_seq: command sequencer
// Runs clear/append in one step and a bounded binary search for lookup,
// one table read per step, using the shared comparator. Holds the result
// in an output register.
// ----------------------------------------------------------------------------
module skts_seq #(
    parameter int TABLE_DEPTH = skts_pkg::DEF_TABLE_DEPTH,
    parameter int KEY_BITS    = skts_pkg::DEF_KEY_BITS,
    parameter int AW          = $clog2(TABLE_DEPTH),
    parameter int CW          = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input transaction
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [skts_pkg::CMD_BITS-1:0]       i_command,
    input  logic [skts_pkg::IN_KEY_BITS-1:0]    i_key,
    // output transaction
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [skts_pkg::STAT_BITS-1:0]      o_status,
    output logic                                o_found,
    output logic [skts_pkg::POS_BITS-1:0]       o_position,
    // table memory
    output logic                                o_wr_en,
    output logic [AW-1:0]                       o_wr_addr,
    output logic [KEY_BITS-1:0]                 o_wr_data,
    output logic                                o_rd_en,
    output logic [AW-1:0]                       o_rd_addr,
    input  logic [KEY_BITS-1:0]                 i_rd_data,
    // shared comparator
    output logic [KEY_BITS-1:0]                 o_cmp_stored,
    output logic [KEY_BITS-1:0]                 o_cmp_probe,
    input  skts_pkg::t_cmp                      i_cmp
);

    localparam int PB = skts_pkg::POS_BITS;
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_RESULT
    } t_state;

    t_state r_state, n_state;

    logic [CW-1:0]       r_count, n_count;
    logic [KEY_BITS-1:0] r_last_key, n_last_key;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [CW-1:0]       r_lo, n_lo;
    logic [CW-1:0]       r_hi, n_hi;
    logic [CW-1:0]       r_mid, n_mid;
    logic                r_eq, n_eq;

    logic [PB-1:0]                  r_res_pos, n_res_pos;
    logic                           r_res_found, n_res_found;
    logic [skts_pkg::STAT_BITS-1:0] r_res_status, n_res_status;

    logic                           r_out_valid, n_out_valid;
    logic [PB-1:0]                  r_out_pos, n_out_pos;
    logic                           r_out_found, n_out_found;
    logic [skts_pkg::STAT_BITS-1:0] r_out_status, n_out_status;

    logic                                    in_acc;
    logic [KEY_BITS+skts_pkg::IN_KEY_BITS-1:0] key_wide;
    logic [KEY_BITS-1:0]                     key_ext;
    logic [CW+PB-1:0]                        cnt_wide;
    logic [CW+PB-1:0]                        lo_wide;
    logic [CW-1:0]                           s_lo, s_hi;
    logic                                    s_eq;
    logic [CW:0]                             s_sum;
    logic [CW-1:0]                           s_mid;
    logic [CW-1:0]                           st_mid;

    assign in_acc = i_in_valid && !o_in_stall;

    // key masked or zero-extended to the table key width
    assign key_wide = {{KEY_BITS{1'b0}}, i_key};
    assign key_ext  = key_wide[KEY_BITS-1:0];

    // shared comparator: last key on append, table read during search
    assign o_cmp_stored = (r_state == S_IDLE) ? r_last_key : i_rd_data;
    assign o_cmp_probe  = (r_state == S_IDLE) ? key_ext : r_key;

    // one search step: narrow [lo, hi) around the probed midpoint
    assign s_lo  = i_cmp.lt ? (r_mid + CW'(1)) : r_lo;
    assign s_hi  = i_cmp.lt ? r_hi : r_mid;
    assign s_eq  = i_cmp.lt ? r_eq : i_cmp.eq;
    assign s_sum = {1'b0, s_lo} + {1'b0, s_hi};
    assign s_mid = s_sum[CW:1];
    assign st_mid = r_count >> 1;

    // index to position field width
    assign cnt_wide = {{PB{1'b0}}, r_count};
    assign lo_wide  = {{PB{1'b0}}, s_lo};

    assign o_wr_addr = r_count[AW-1:0];
    assign o_wr_data = key_ext;

    // next-state logic
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_last_key   = r_last_key;
        n_key        = r_key;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_mid        = r_mid;
        n_eq         = r_eq;
        n_res_pos    = r_res_pos;
        n_res_found  = r_res_found;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_pos    = r_out_pos;
        n_out_found  = r_out_found;
        n_out_status = r_out_status;
        o_wr_en      = 1'b0;
        o_rd_en      = 1'b0;
        o_rd_addr    = s_mid[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_key        = key_ext;
                    n_res_pos    = '0;
                    n_res_found  = 1'b0;
                    n_res_status = skts_pkg::ST_OK;
                    n_state      = S_RESULT;
                    unique case (i_command)
                        skts_pkg::CMD_CLEAR: begin
                            n_count = '0;
                        end
                        skts_pkg::CMD_APPEND: begin
                            if (r_count == FULL_COUNT) begin
                                n_res_status = skts_pkg::ST_FULL;
                            end else if (r_count != '0 && !i_cmp.lt) begin
                                n_res_status = skts_pkg::ST_ORDER;
                            end else begin
                                o_wr_en    = 1'b1;
                                n_count    = r_count + CW'(1);
                                n_last_key = key_ext;
                                n_res_pos  = cnt_wide[PB-1:0];
                            end
                        end
                        skts_pkg::CMD_LOOKUP: begin
                            if (r_count != '0) begin
                                n_lo      = '0;
                                n_hi      = r_count;
                                n_mid     = st_mid;
                                n_eq      = 1'b0;
                                o_rd_en   = 1'b1;
                                o_rd_addr = st_mid[AW-1:0];
                                n_state   = S_SEARCH;
                            end
                        end
                        default: begin
                            // unused code: reports ok with no position; table unchanged
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                n_lo = s_lo;
                n_hi = s_hi;
                n_eq = s_eq;
                if (s_lo < s_hi) begin
                    n_mid   = s_mid;
                    o_rd_en = 1'b1;
                end else begin
                    // final lo equals the last hi taken; eq tracks that entry
                    n_res_found = s_eq;
                    n_res_pos   = s_eq ? lo_wide[PB-1:0] : '0;
                    n_state     = S_RESULT;
                end
            end
            S_RESULT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_pos    = r_res_pos;
                    n_out_found  = r_res_found;
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        r_last_key   <= n_last_key;
        r_key        <= n_key;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_mid        <= n_mid;
        r_eq         <= n_eq;
        r_res_pos    <= n_res_pos;
        r_res_found  <= n_res_found;
        r_res_status <= n_res_status;
        r_out_pos    <= n_out_pos;
        r_out_found  <= n_out_found;
        r_out_status <= n_out_status;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_found     = r_out_found;
    assign o_position  = r_out_pos;

endmodule

[sv/sorted_key_table_search.sv]
// ----------------------------------------------------------------------------
// sorted_key_table_search: sorted key table with bounded binary search
// Keys are appended in strictly ascending order; lookups bisect the table.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (i_in_valid / o_in_stall) carries a command and a key:
//   clear, append or lookup. Output channel (o_out_valid / i_out_stall)
//   returns status, found and position: one result transaction per command.
//   Clear and append pass from the accept to the result state and then
//   into the output register. A lookup first runs bisection steps over
//   the n stored entries, each step one table RAM read feeding the
//   shared comparator. An empty-table lookup goes straight to the result.
//   o_in_stall is high from the accept until the result moves into the
//   output register, so a new command is taken only after the last one's
//   result has moved there. While the receiver stalls, the result holds;
//   the block takes the next command meanwhile but cannot hand off its
//   result until the output register frees.
//   Reset (synchronous, active low) empties the table and drops any
//   pending result. The table RAM is not cleared; entries past the count
//   are never read.
// ----------------------------------------------------------------------------
module sorted_key_table_search #(
    parameter int TABLE_DEPTH = skts_pkg::DEF_TABLE_DEPTH,
    parameter int KEY_BITS    = skts_pkg::DEF_KEY_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [skts_pkg::CMD_BITS-1:0]    i_command,
    input  logic [skts_pkg::IN_KEY_BITS-1:0] i_key,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [skts_pkg::STAT_BITS-1:0]   o_status,
    output logic                             o_found,
    output logic [skts_pkg::POS_BITS-1:0]    o_position
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [KEY_BITS-1:0] wr_data;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic [KEY_BITS-1:0] rd_data;
    logic [KEY_BITS-1:0] cmp_stored;
    logic [KEY_BITS-1:0] cmp_probe;
    skts_pkg::t_cmp      cmp_res;

    // sequencer
    skts_seq #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (KEY_BITS),
        .AW          (AW),
        .CW          (CW)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_key        (i_key),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_found      (o_found),
        .o_position   (o_position),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data),
        .o_cmp_stored (cmp_stored),
        .o_cmp_probe  (cmp_probe),
        .i_cmp        (cmp_res)
    );

    // shared comparator
    skts_cmp #(
        .KEY_BITS (KEY_BITS)
    ) u_cmp (
        .i_stored (cmp_stored),
        .i_probe  (cmp_probe),
        .o_res    (cmp_res)
    );

    // key table
    skts_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule

[sv/skts_chk.sv]
// ----------------------------------------------------------------------------
// skts_chk: port-level checks for the sorted key table search
// Watches the transaction ports; bound to the top level.
// ----------------------------------------------------------------------------
module skts_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_stall,
    input logic [skts_pkg::CMD_BITS-1:0]    i_command,
    input logic [skts_pkg::IN_KEY_BITS-1:0] i_key,
    input logic                             o_out_valid,
    input logic                             i_out_stall,
    input logic [skts_pkg::STAT_BITS-1:0]   o_status,
    input logic                             o_found,
    input logic [skts_pkg::POS_BITS-1:0]    o_position
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_status) && $stable(o_found) && $stable(o_position))
        else $error("result changed while stalled");

    // one command at a time: stall right after an accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after accept");

    // a hit only comes with ok status
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_found |-> o_status == skts_pkg::ST_OK)
        else $error("found with error status");

    // a refused append reports no position
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == skts_pkg::ST_FULL || o_status == skts_pkg::ST_ORDER)
            |-> !o_found && o_position == '0)
        else $error("error result with nonzero fields");

    // unused status code never appears
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status != skts_pkg::ST_UNUSED)
        else $error("unused status code");

endmodule

bind sorted_key_table_search skts_chk u_skts_chk (.*);

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: testbench for sorted_key_table_search
// Sends clear, append and lookup transactions with random idle gaps on both
// channels. Each accepted transaction is predicted by a local copy of the
// key table and its bounded binary search. Results are checked field by
// field in order. Covers order errors, a table filled to capacity, lookups
// on empty and full tables, and the unused command code.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int TABLE_DEPTH    = skts_pkg::DEF_TABLE_DEPTH;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int RANDOM_ITEMS   = 2000;

    // the spare command code; the block answers it with ok and leaves the table unchanged
    localparam logic [skts_pkg::CMD_BITS-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [skts_pkg::CMD_BITS-1:0]    command;
        logic [skts_pkg::IN_KEY_BITS-1:0] key;
        logic                             drain_first;  // wait for all results first
    } t_table_cmd;

    typedef struct packed {
        logic [skts_pkg::STAT_BITS-1:0] status;
        logic                           found;
        logic [skts_pkg::POS_BITS-1:0]  position;
    } t_search_result;

    logic                             i_clk       = 1'b0;
    logic                             i_rst_n     = 1'b0;
    logic                             i_in_valid  = 1'b0;
    logic [skts_pkg::CMD_BITS-1:0]    i_command   = skts_pkg::CMD_CLEAR;
    logic [skts_pkg::IN_KEY_BITS-1:0] i_key       = '0;
    logic                             i_out_stall = 1'b0;
    logic                             o_in_stall;
    logic                             o_out_valid;
    logic [skts_pkg::STAT_BITS-1:0]   o_status;
    logic                             o_found;
    logic [skts_pkg::POS_BITS-1:0]    o_position;

    t_table_cmd     cmd_backlog[$];
    t_search_result search_results_due[$];
    int             due_count    = 0;
    logic           stim_done    = 1'b0;
    int             mismatches   = 0;
    int             cycle_count  = 0;
    int             quiet_cycles = 0;
    logic           quiet_stretch;

    // local copy of the key table
    logic [skts_pkg::IN_KEY_BITS-1:0] table_keys [TABLE_DEPTH];
    int unsigned                      table_fill = 0;

    sorted_key_table_search u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_command   (i_command),
        .i_key       (i_key),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_found     (o_found),
        .o_position  (o_position)
    );

    always #5 i_clk = ~i_clk;

    // periodic stretch where neither side idles
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end
    assign quiet_stretch = (cycle_count % 3000) >= 2200;

    task automatic add_item(input logic [skts_pkg::CMD_BITS-1:0] command,
                            input logic [skts_pkg::IN_KEY_BITS-1:0] key,
                            input logic drain_first);
        t_table_cmd item;
        item.command     = command;
        item.key         = key;
        item.drain_first = drain_first;
        cmd_backlog.push_back(item);
    endtask

    // expected result of one command, applied to the local table
    task automatic predict_table_op(input logic [skts_pkg::CMD_BITS-1:0] command,
                                    input logic [skts_pkg::IN_KEY_BITS-1:0] key);
        t_search_result res;
        int unsigned    lo;
        int unsigned    hi;
        int unsigned    mid;
        res = '0;
        case (command)
            skts_pkg::CMD_CLEAR: begin
                table_fill = 0;
            end
            skts_pkg::CMD_APPEND: begin
                if (table_fill >= TABLE_DEPTH) begin
                    res.status = skts_pkg::ST_FULL;
                end else if (table_fill > 0 && key <= table_keys[table_fill-1]) begin
                    res.status = skts_pkg::ST_ORDER;
                end else begin
                    table_keys[table_fill] = key;
                    res.position = table_fill[skts_pkg::POS_BITS-1:0];
                    table_fill++;
                end
            end
            skts_pkg::CMD_LOOKUP: begin
                // lower-bound bisection over the filled part
                lo = 0;
                hi = table_fill;
                while (lo < hi) begin
                    mid = lo + (hi - lo) / 2;
                    if (table_keys[mid] < key) lo = mid + 1;
                    else hi = mid;
                end
                if (lo < table_fill && table_keys[lo] == key) begin
                    res.found    = 1'b1;
                    res.position = lo[skts_pkg::POS_BITS-1:0];
                end
            end
            default: ;
        endcase
        search_results_due.push_back(res);
    endtask

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("tb: mismatch: %s", msg);
    endtask

    // driver: one transaction at a time, payload held while stalled
    always @(posedge i_clk) begin
        logic       taken;
        logic       send;
        t_table_cmd cur;
        taken = i_in_valid && !o_in_stall;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!(i_in_valid && !taken)) begin
            send = cmd_backlog.size() > 0 && (quiet_stretch || $urandom_range(99) >= 35);
            if (send && cmd_backlog[0].drain_first && (due_count != 0 || taken)) send = 1'b0;
            if (send) begin
                cur = cmd_backlog.pop_front();
                i_command <= cur.command;
                i_key     <= cur.key;
            end else if (cmd_backlog.size() == 0) begin
                stim_done <= 1'b1;
            end
            i_in_valid <= send;
        end
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_out_stall <= !quiet_stretch && ($urandom_range(99) < 35);
    end

    // monitor: check outgoing results, then predict incoming commands
    always @(posedge i_clk) begin
        t_search_result want;
        int             delta;
        delta = 0;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (search_results_due.size() == 0) begin
                    note_mismatch($sformatf("unexpected result st=%0d found=%0d pos=%0d",
                                            o_status, o_found, o_position));
                end else begin
                    want = search_results_due.pop_front();
                    delta--;
                    if (o_status !== want.status)
                        note_mismatch($sformatf("status exp %0d got %0d",
                                                want.status, o_status));
                    if (o_found !== want.found)
                        note_mismatch($sformatf("found exp %0d got %0d",
                                                want.found, o_found));
                    if (o_position !== want.position)
                        note_mismatch($sformatf("position exp %0d got %0d",
                                                want.position, o_position));
                end
            end
            if (i_in_valid && !o_in_stall) begin
                predict_table_op(i_command, i_key);
                delta++;
            end
            due_count <= due_count + delta;
        end
    end

    // watchdog: no transaction on either channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stimulus build, reset and end of run
    initial begin
        logic [skts_pkg::IN_KEY_BITS-1:0] gen_keys[$];
        logic [32:0]                      next_key;
        int                               base;
        int                               m;
        int                               k;
        int                               pick;
        int                               step_max;

        // directed: empty table, key extremes, order errors, unused code
        add_item(skts_pkg::CMD_LOOKUP, 32'h0000_0000, 1'b0);
        add_item(skts_pkg::CMD_APPEND, 32'h0000_0000, 1'b0);
        add_item(skts_pkg::CMD_APPEND, 32'h0000_0000, 1'b0);   // equal to last
        add_item(skts_pkg::CMD_LOOKUP, 32'h0000_0000, 1'b0);
        add_item(skts_pkg::CMD_APPEND, 32'h8000_0000, 1'b0);
        add_item(skts_pkg::CMD_APPEND, 32'h7FFF_FFFF, 1'b0);   // below last
        add_item(skts_pkg::CMD_APPEND, 32'hFFFF_FFFF, 1'b0);
        add_item(skts_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 1'b0);
        add_item(skts_pkg::CMD_LOOKUP, 32'h5555_5555, 1'b0);
        add_item(skts_pkg::CMD_APPEND, 32'hFFFF_FFFF, 1'b0);
        add_item(CMD_UNUSED, 32'hAAAA_AAAA, 1'b0);
        add_item(skts_pkg::CMD_LOOKUP, 32'h8000_0000, 1'b0);
        add_item(skts_pkg::CMD_CLEAR,  32'hFFFF_FFFF, 1'b0);
        add_item(skts_pkg::CMD_LOOKUP, 32'h0000_0000, 1'b0);
        add_item(skts_pkg::CMD_APPEND, 32'h0000_0001, 1'b0);
        add_item(skts_pkg::CMD_LOOKUP, 32'h0000_0000, 1'b0);
        add_item(skts_pkg::CMD_LOOKUP, 32'h0000_0002, 1'b0);
        add_item(skts_pkg::CMD_LOOKUP, 32'h0000_0001, 1'b0);
        add_item(CMD_UNUSED, 32'h5555_5555, 1'b0);
        add_item(skts_pkg::CMD_LOOKUP, 32'h0000_0001, 1'b0);

        base = cmd_backlog.size();
        for (int phase = 0; phase < 2; phase++) begin
            while (cmd_backlog.size() - base < RANDOM_ITEMS / 2) begin
                if ($urandom_range(99) < 75) begin
                    // ascending fill then lookups, a few out-of-order appends mixed in
                    add_item(skts_pkg::CMD_CLEAR, $urandom, 1'b0);
                    gen_keys.delete();
                    m = ($urandom_range(9) == 0) ? $urandom_range(300, 65)
                                                 : $urandom_range(40, 1);
                    case ($urandom_range(3))
                        0: step_max = 1;
                        1: step_max = 16;
                        2: step_max = 65536;
                        default: step_max = 32'h0400_0000;
                    endcase
                    next_key = $urandom_range(1) ? {1'b0, 32'($urandom_range(255))}
                                                 : {1'b0, $urandom};
                    for (int i = 0; i < m; i++) begin
                        if ($urandom_range(19) == 0 && gen_keys.size() > 0) begin
                            add_item(skts_pkg::CMD_APPEND,
                                     gen_keys[$urandom_range(gen_keys.size() - 1)], 1'b0);
                        end else begin
                            add_item(skts_pkg::CMD_APPEND, next_key[31:0], 1'b0);
                            gen_keys.push_back(next_key[31:0]);
                            next_key = next_key + $urandom_range(step_max, 1);
                            if (next_key[32]) break;
                        end
                    end
                    k = $urandom_range(m + 4, 1);
                    for (int j = 0; j < k; j++) begin
                        pick = $urandom_range(9);
                        if (gen_keys.size() == 0 || pick >= 8)
                            add_item(skts_pkg::CMD_LOOKUP, $urandom, 1'b0);
                        else if (pick == 6)
                            add_item(skts_pkg::CMD_LOOKUP,
                                     gen_keys[$urandom_range(gen_keys.size() - 1)] - 1, 1'b0);
                        else if (pick == 7)
                            add_item(skts_pkg::CMD_LOOKUP,
                                     gen_keys[$urandom_range(gen_keys.size() - 1)] + 1, 1'b0);
                        else
                            add_item(skts_pkg::CMD_LOOKUP,
                                     gen_keys[$urandom_range(gen_keys.size() - 1)], 1'b0);
                    end
                end else begin
                    // noise: any command code with any key
                    k = $urandom_range(4, 1);
                    for (int j = 0; j < k; j++)
                        add_item(skts_pkg::CMD_BITS'($urandom_range(3)), $urandom, 1'b0);
                end
            end

            if (phase == 0) begin
                // fill the table to capacity after a full drain
                add_item(skts_pkg::CMD_CLEAR, $urandom, 1'b1);
                gen_keys.delete();
                next_key = {1'b0, 32'($urandom_range(1000))};
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    add_item(skts_pkg::CMD_APPEND, next_key[31:0], 1'b0);
                    gen_keys.push_back(next_key[31:0]);
                    next_key = next_key + $urandom_range(1000000, 1);
                end
                // full takes priority over the order check
                add_item(skts_pkg::CMD_APPEND, 32'hFFFF_FFFF, 1'b0);
                add_item(skts_pkg::CMD_APPEND, 32'h0000_0000, 1'b0);
                add_item(skts_pkg::CMD_LOOKUP, gen_keys[0], 1'b0);
                add_item(skts_pkg::CMD_LOOKUP, gen_keys[TABLE_DEPTH-1], 1'b0);
                add_item(skts_pkg::CMD_LOOKUP, gen_keys[TABLE_DEPTH-1] + 1, 1'b0);
                for (int j = 0; j < 12; j++) begin
                    pick = $urandom_range(TABLE_DEPTH - 1);
                    add_item(skts_pkg::CMD_LOOKUP, gen_keys[pick], 1'b0);
                    add_item(skts_pkg::CMD_LOOKUP, gen_keys[pick] - 1, 1'b0);
                    add_item(skts_pkg::CMD_LOOKUP, $urandom, 1'b0);
                end
                add_item(CMD_UNUSED, $urandom, 1'b0);
                add_item(skts_pkg::CMD_APPEND, $urandom, 1'b0);
                base = cmd_backlog.size();
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!(stim_done && due_count == 0)) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
